>>> rtl/bti_pkg.sv
// Shared types and constants for the breakpoint table interpolator.
// Depends on nothing; every other file imports it.
package bti_pkg;

	localparam int MAX_ROWS = 32;
	localparam int MAX_COLS = 8;
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int DEPTH = MAX_ROWS * MAX_COLS;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_LOOK1 = 2'd1;
	localparam logic [1:0] CMD_LOOK2 = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DEGEN = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;
	localparam logic [1:0] ST_WRITE = 2'd3;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	// Request to and answer from the shared interpolation step unit
	typedef struct packed {
		logic signed [32:0] num;
		logic signed [32:0] den;
		logic signed [32:0] dv;
		logic signed [31:0] v0;
	} lerp_req_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic degen;
		logic sat;
	} lerp_rsp_t;

endpackage

>>> rtl/bti_lerp.sv
// Multi-cycle linear step: v0 + trunc(num*dv/den), saturated to 32 bits.
// Uses bti_pkg; one 32x32 product, then a restoring divider one bit per cycle.
module bti_lerp import bti_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      go,
	input  lerp_req_t req,
	output logic      done,
	output lerp_rsp_t rsp
);

	typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV, L_FIN} lstate_t;

	lstate_t          st_q;
	logic [6:0]       cnt_q;
	logic [63:0]      prod_q;
	logic [63:0]      quo_q;
	logic [32:0]      rem_q;
	logic [32:0]      ud_q;
	logic [31:0]      un_q;
	logic [31:0]      uv_q;
	logic             neg_q;
	logic signed [31:0] v0_q;

	logic [33:0]      rem_sh;
	logic [33:0]      rem_sub;
	logic [33:0]      qsat;
	logic signed [35:0] sum;

	always_comb begin
		rem_sh = {rem_q, prod_q[63]};
		rem_sub = rem_sh - {1'b0, ud_q};
		qsat = (quo_q > 64'h2_0000_0000) ? 34'h2_0000_0000 : quo_q[33:0];
		sum = {{4{v0_q[31]}}, v0_q} + (neg_q ? -$signed({2'b00, qsat}) : $signed({2'b00, qsat}));
	end

	// Sequence magnitudes, product, long division and saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= L_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				L_IDLE: begin
					if (go) begin
						neg_q <= (req.num[32] ^ req.dv[32]) ^ req.den[32];
						un_q <= req.num[32] ? 32'(-req.num) : 32'(req.num);
						uv_q <= req.dv[32] ? 32'(-req.dv) : 32'(req.dv);
						ud_q <= req.den[32] ? 33'(-req.den) : 33'(req.den);
						v0_q <= req.v0;
						rsp.degen <= (req.den == '0);
						st_q <= L_MUL;
					end
				end
				L_MUL: begin
					prod_q <= 64'(un_q) * 64'(uv_q);
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= 7'd0;
					st_q <= rsp.degen ? L_FIN : L_DIV;
				end
				L_DIV: begin
					if (!rem_sub[33]) begin
						rem_q <= rem_sub[32:0];
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= rem_sh[32:0];
						quo_q <= {quo_q[62:0], 1'b0};
					end
					prod_q <= {prod_q[62:0], 1'b0};
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd63) st_q <= L_FIN;
				end
				L_FIN: begin
					rsp.sat <= 1'b0;
					if (rsp.degen) begin
						rsp.value <= '0;
					end else if (sum > 36'sd2147483647) begin
						rsp.value <= 32'h7FFF_FFFF;
						rsp.sat <= 1'b1;
					end else if (sum < -36'sd2147483648) begin
						rsp.value <= 32'h8000_0000;
						rsp.sat <= 1'b1;
					end else begin
						rsp.value <= sum[31:0];
					end
					done <= 1'b1;
					st_q <= L_IDLE;
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("lerp done held");
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> st_q == L_IDLE) else $error("lerp started while busy");
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.sat) |-> (rsp.value == 32'h7FFF_FFFF || rsp.value == 32'h8000_0000))
		else $error("saturation flag without saturated value");
`endif

endmodule

>>> rtl/breakpoint_table_interpolator_core.sv
// Breakpoint table interpolator top level: table memory, sequencer, config; uses bti_pkg, bti_lerp.
// A write, or too few rows/cols, goes straight to the result; a 1D or 2D lookup first searches
// the one-port table, then runs its lerps through the restoring divider in bti_lerp
// (a zero-width interval skips the divide).
// One request at a time: busy is high until done pulses; the next is taken in the done cycle.
// Reset clears control state and sets rows_in_use 32, cols_in_use 8; table undefined.
module breakpoint_table_interpolator_core import bti_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [4:0]         row_index,
	input  logic [2:0]         col_index,
	input  logic signed [31:0] entry_value,
	input  logic signed [31:0] first_key,
	input  logic signed [31:0] second_key,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               done,
	output logic signed [31:0] result_value,
	output logic [1:0]         status
);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_SRCH, S_RDK, S_RDV, S_LERP, S_WAIT, S_OUT
	} state_t;

	logic [5:0]  rows_q;
	logic [3:0]  cols_q;
	state_t      st_q;

	logic signed [31:0] mem [DEPTH];
	logic [ADDR_W-1:0]  raddr;
	logic signed [31:0] rdata_q;

	logic [1:0]  cmd_q;
	logic signed [31:0] x_q, y_q;
	logic [ROW_W:0] eff_r, r_q;
	logic [COL_W:0] eff_c, c_q;
	logic        phase_q;   // 0 row search, 1 column search
	logic [2:0]  rd_q;      // step in operand fetch
	logic [1:0]  pass_q;    // which lerp of the lookup
	logic signed [31:0] k0_q, k1_q, v0_q, v1_q, a_q;
	logic        degen_q, sat_q;
	logic        issue_q;
	lerp_req_t   lreq;
	lerp_rsp_t   lrsp;
	logic        ldone;

	assign eff_r = (rows_q > 6'(MAX_ROWS)) ? (ROW_W+1)'(MAX_ROWS) : rows_q[ROW_W:0];
	assign eff_c = (cols_q > 4'(MAX_COLS)) ? (COL_W+1)'(MAX_COLS) : cols_q[COL_W:0];
	assign busy = (st_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 6'd32;
			cols_q <= 4'd8;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROWS: rows_q <= cfg_data[5:0];
				REG_COLS: cols_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Address selection for the single read port
	logic [ROW_W-1:0] ar;
	logic [COL_W-1:0] ac;
	logic [ROW_W-1:0] rm1, rr;
	logic [COL_W-1:0] cm1, cc, vcol;
	always_comb begin
		rr = r_q[ROW_W-1:0];
		rm1 = ROW_W'(r_q - 1'b1);
		cc = c_q[COL_W-1:0];
		cm1 = COL_W'(c_q - 1'b1);
		vcol = (cmd_q == CMD_LOOK1) ? COL_W'(1) : ((pass_q == 2'd0) ? cm1 : cc);
		ar = '0;
		ac = '0;
		if (st_q == S_SRCH || st_q == S_RD) begin
			ar = phase_q ? '0 : rr;
			ac = phase_q ? cc : '0;
		end else if (pass_q == 2'd2) begin
			case (rd_q)
				3'd0: ac = cm1;
				3'd1: ac = cc;
				default: ;
			endcase
		end else begin
			case (rd_q)
				3'd0: ar = rm1;
				3'd1: ar = rr;
				3'd2: begin ar = rm1; ac = vcol; end
				default: begin ar = rr; ac = vcol; end
			endcase
		end
		raddr = {ar, ac};
	end

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && start && command == CMD_WRITE)
			mem[{row_index[ROW_W-1:0], col_index[COL_W-1:0]}] <= entry_value;
		rdata_q <= mem[raddr];
	end

	logic [ROW_W:0] r_lo;
	logic [COL_W:0] c_lo;
	logic signed [31:0] q_now;
	assign r_lo = (cmd_q == CMD_LOOK1) ? (ROW_W+1)'(1) : (ROW_W+1)'(2);
	assign c_lo = (COL_W+1)'(2);
	assign q_now = phase_q ? y_q : x_q;

	always_comb begin
		lreq.num = pass_q == 2'd2 ? 33'(y_q) - 33'(k0_q) : 33'(x_q) - 33'(k0_q);
		lreq.den = 33'(k1_q) - 33'(k0_q);
		lreq.dv = 33'(v1_q) - 33'(v0_q);
		lreq.v0 = v0_q;
	end

	bti_lerp u_lerp (
		.clk(clk), .arst_n(arst_n), .go(issue_q), .req(lreq), .done(ldone), .rsp(lrsp)
	);

	// Sequencer: search, fetch operands, run lerps, report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
			issue_q <= 1'b0;
		end else begin
			done <= 1'b0;
			issue_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= command;
						x_q <= first_key;
						y_q <= second_key;
						degen_q <= 1'b0;
						sat_q <= 1'b0;
						phase_q <= 1'b0;
						pass_q <= 2'd0;
						rd_q <= '0;
						c_q <= (COL_W+1)'(1);
						if (command == CMD_WRITE) begin
							result_value <= '0;
							status <= ST_WRITE;
							st_q <= S_OUT;
						end else if (command == CMD_LOOK1 && eff_r >= 2 && eff_c >= 2) begin
							r_q <= '0;
							st_q <= S_RD;
						end else if (command == CMD_LOOK2 && eff_r >= 3 && eff_c >= 3) begin
							r_q <= (ROW_W+1)'(1);
							st_q <= S_RD;
						end else begin
							result_value <= '0;
							status <= ST_DEGEN;
							st_q <= S_OUT;
						end
					end
				end
				S_RD: st_q <= S_SRCH;
				S_SRCH: begin
					// rdata_q holds the key at the current index
					if (!phase_q) begin
						if (r_q < eff_r && rdata_q < q_now) begin
							r_q <= r_q + 1'b1;
							st_q <= S_RD;
						end else begin
							if (r_q < r_lo) r_q <= r_lo;
							else if (r_q == eff_r) r_q <= r_q - 1'b1;
							if (cmd_q == CMD_LOOK2) begin
								phase_q <= 1'b1;
								st_q <= S_RD;
							end else begin
								st_q <= S_RDK;
							end
						end
					end else begin
						if (c_q < eff_c && rdata_q < q_now) begin
							c_q <= c_q + 1'b1;
							st_q <= S_RD;
						end else begin
							if (c_q < c_lo) c_q <= c_lo;
							else if (c_q == eff_c) c_q <= c_q - 1'b1;
							st_q <= S_RDK;
						end
					end
				end
				S_RDK: begin
					// Address for rd_q issued this cycle; data arrives next
					st_q <= S_RDV;
				end
				S_RDV: begin
					case (rd_q)
						3'd0: k0_q <= rdata_q;
						3'd1: k1_q <= rdata_q;
						3'd2: v0_q <= rdata_q;
						default: v1_q <= rdata_q;
					endcase
					if (pass_q == 2'd2 && rd_q == 3'd1) begin
						st_q <= S_LERP;
					end else if (rd_q == 3'd3) begin
						st_q <= S_LERP;
					end else begin
						rd_q <= rd_q + 1'b1;
						st_q <= S_RDK;
					end
				end
				S_LERP: begin
					if (pass_q == 2'd2) begin
						v0_q <= a_q;
						v1_q <= lrsp.value;
					end
					issue_q <= 1'b1;
					st_q <= S_WAIT;
				end
				S_WAIT: begin
					if (ldone) begin
						rd_q <= '0;
						if (lrsp.degen) degen_q <= 1'b1;
						if (lrsp.sat) sat_q <= 1'b1;
						if (cmd_q == CMD_LOOK2 && pass_q == 2'd0) begin
							a_q <= lrsp.value;
							pass_q <= 2'd1;
							st_q <= S_RDK;
						end else if (cmd_q == CMD_LOOK2 && pass_q == 2'd1 &&
								!(degen_q || lrsp.degen)) begin
							pass_q <= 2'd2;
							st_q <= S_RDK;
						end else begin
							if (degen_q || lrsp.degen) begin
								result_value <= '0;
								status <= ST_DEGEN;
							end else begin
								result_value <= lrsp.value;
								status <= (sat_q || lrsp.sat) ? ST_SAT : ST_OK;
							end
							st_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					done <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held");
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request accepted but not busy");
	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while still busy");
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_DEGEN) |-> result_value == '0)
		else $error("degenerate result not zero");
`endif

endmodule
